/* rtl/core/sld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_pkg
// Shared constants and types for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

	// window and output queue geometry
	localparam int WIN_DEPTH = 4096;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int WFILL_W   = $clog2(WIN_DEPTH + 1);
	localparam int QUE_DEPTH = 4096;
	localparam int QUE_AW    = $clog2(QUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUE_DEPTH + 1);

	// frame layout
	localparam int LEN_LO_OFS  = 16;
	localparam int LEN_HI_OFS  = 17;
	localparam int MIN_HEAD    = 18;
	localparam int FRAME_EXTRA = 19;
	localparam int FLEN_W      = 17;

	// command codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// configuration register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic               out_valid;
		logic [7:0]         out_byte;
		logic               out_last;
		logic [31:0]        good_frames;
		logic [31:0]        bad_frames;
		logic [31:0]        dropped_frames;
		logic [QCNT_W-1:0]  queued_bytes;
	} res_t;

endpackage

/* rtl/core/sld_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/sld_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_front
// Input side: takes push/pop transactions and buffers them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module sld_front
	import sld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] byte_in,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q].action <= (action == ACT_POP) ? ACT_POP : ACT_PUSH;
			fifo_q[wptr_q].data   <= byte_in;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/core/sld_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_back
// Execution side: holds the byte window and the output queue, runs the
// sync hunt, length check and checksum scan, and registers each result.
// ----------------------------------------------------------------------------
module sld_back
	import sld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_CHK0, ST_CHK1, ST_LEN0,
		ST_LEN1, ST_SUM, ST_COPY, ST_POP, ST_DONE
	} state_t;

	state_t              state_q;
	logic [7:0]          sync_first_q;
	logic [7:0]          sync_second_q;
	logic [WIN_AW-1:0]   wstart_q;
	logic [WFILL_W-1:0]  wfill_q;
	logic [QUE_AW-1:0]   qhead_q;
	logic [QCNT_W-1:0]   qcount_q;
	logic [31:0]         good_q;
	logic [31:0]         bad_q;
	logic [31:0]         drop_q;
	logic [7:0]          len_lo_q;
	logic [WFILL_W-1:0]  flen_q;
	logic [WIN_AW-1:0]   k_q;
	logic [7:0]          sum_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                take;
	logic [WIN_AW-1:0]   rofs;
	logic [WIN_AW-1:0]   win_raddr;
	logic [7:0]          win_rdata;
	logic                win_we;
	logic [WIN_AW-1:0]   win_waddr;
	logic                que_we;
	logic [QUE_AW-1:0]   que_waddr;
	logic [8:0]          que_rdata;
	logic [WFILL_W-1:0]  k_next;
	logic [FLEN_W-1:0]   flen_full;
	logic [QCNT_W:0]     q_after;
	logic                copy_last;

	assign take      = (state_q == ST_IDLE) && !res_valid_q && cmd_valid;
	assign cmd_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign k_next    = {1'b0, k_q} + WFILL_W'(1);
	assign flen_full = {win_rdata, len_lo_q} + FLEN_W'(FRAME_EXTRA);
	assign q_after   = {1'b0, qcount_q} + (QCNT_W+1)'(flen_q);
	assign copy_last = (k_next == flen_q);

	// window read offset for the next cycle
	always_comb begin
		case (state_q)
			ST_CHK0: rofs = WIN_AW'(1);
			ST_CHK1: rofs = WIN_AW'(LEN_LO_OFS);
			ST_LEN0: rofs = WIN_AW'(LEN_HI_OFS);
			ST_LEN1: rofs = WIN_AW'(LEN_LO_OFS);
			ST_SUM:  rofs = (k_next < flen_q) ? k_next[WIN_AW-1:0] : '0;
			ST_COPY: rofs = k_next[WIN_AW-1:0];
			default: rofs = '0;
		endcase
	end

	assign win_raddr = wstart_q + rofs;
	// a push into a full window lands on the oldest byte, which is dropped
	assign win_we    = take && (cmd.action == ACT_PUSH);
	assign win_waddr = wstart_q + wfill_q[WIN_AW-1:0];
	assign que_we    = (state_q == ST_COPY);
	assign que_waddr = qhead_q + qcount_q[QUE_AW-1:0];

	sld_ram #(.WIDTH(8), .DEPTH(WIN_DEPTH)) u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (cmd.data),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	sld_ram #(.WIDTH(9), .DEPTH(QUE_DEPTH)) u_que (
		.clk   (clk),
		.we    (que_we),
		.waddr (que_waddr),
		.wdata ({copy_last, win_rdata}),
		.raddr (qhead_q),
		.rdata (que_rdata)
	);

	// datapath registers with no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LEN0: len_lo_q <= win_rdata;
			ST_LEN1: begin
				flen_q <= flen_full[WFILL_W-1:0];
				k_q    <= WIN_AW'(LEN_LO_OFS);
				sum_q  <= 8'd0;
			end
			ST_SUM: begin
				if (k_next < flen_q) begin
					sum_q <= sum_q + win_rdata;
					k_q   <= k_next[WIN_AW-1:0];
				end else begin
					k_q <= '0;
				end
			end
			ST_COPY: k_q <= k_next[WIN_AW-1:0];
			default: ;
		endcase
	end

	// sequencer, window and queue bookkeeping, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sync_first_q  <= 8'd170;
			sync_second_q <= 8'd85;
			wstart_q      <= '0;
			wfill_q       <= '0;
			qhead_q       <= '0;
			qcount_q      <= '0;
			good_q        <= '0;
			bad_q         <= '0;
			drop_q        <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_SYNC_FIRST) begin
					sync_first_q <= cfg_data;
				end else begin
					sync_second_q <= cfg_data;
				end
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (cmd.action == ACT_POP) begin
							state_q <= (qcount_q != '0) ? ST_POP : ST_DONE;
						end else begin
							if (wfill_q == WFILL_W'(WIN_DEPTH)) begin
								wstart_q <= wstart_q + WIN_AW'(1);
							end else begin
								wfill_q <= wfill_q + WFILL_W'(1);
							end
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					state_q <= (wfill_q == '0) ? ST_DONE : ST_CHK0;
				end
				ST_CHK0: begin
					if (win_rdata != sync_first_q) begin
						wstart_q <= wstart_q + WIN_AW'(1);
						wfill_q  <= wfill_q - WFILL_W'(1);
						state_q  <= ST_SCAN;
					end else if (wfill_q > WFILL_W'(1)) begin
						state_q <= ST_CHK1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CHK1: begin
					if (win_rdata != sync_second_q) begin
						wstart_q <= wstart_q + WIN_AW'(1);
						wfill_q  <= wfill_q - WFILL_W'(1);
						state_q  <= ST_SCAN;
					end else if (wfill_q < WFILL_W'(MIN_HEAD)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LEN0;
					end
				end
				ST_LEN0: state_q <= ST_LEN1;
				ST_LEN1: begin
					// oversize length counts as a bad frame
					if (flen_full > FLEN_W'(WIN_DEPTH)) begin
						bad_q    <= bad_q + 32'd1;
						wstart_q <= wstart_q + WIN_AW'(1);
						wfill_q  <= wfill_q - WFILL_W'(1);
						state_q  <= ST_SCAN;
					end else if (flen_full > FLEN_W'(wfill_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (k_next >= flen_q) begin
						if (win_rdata == sum_q) begin
							good_q <= good_q + 32'd1;
							if (q_after <= (QCNT_W+1)'(QUE_DEPTH)) begin
								state_q <= ST_COPY;
							end else begin
								drop_q   <= drop_q + 32'd1;
								wstart_q <= wstart_q + flen_q[WIN_AW-1:0];
								wfill_q  <= wfill_q - flen_q;
								state_q  <= ST_SCAN;
							end
						end else begin
							bad_q    <= bad_q + 32'd1;
							wstart_q <= wstart_q + WIN_AW'(1);
							wfill_q  <= wfill_q - WFILL_W'(1);
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_COPY: begin
					qcount_q <= qcount_q + QCNT_W'(1);
					if (copy_last) begin
						wstart_q <= wstart_q + flen_q[WIN_AW-1:0];
						wfill_q  <= wfill_q - flen_q;
						state_q  <= ST_SCAN;
					end
				end
				ST_POP: begin
					qhead_q               <= qhead_q + QUE_AW'(1);
					qcount_q              <= qcount_q - QCNT_W'(1);
					res_valid_q           <= 1'b1;
					res_q.out_valid       <= 1'b1;
					res_q.out_byte        <= que_rdata[7:0];
					res_q.out_last        <= que_rdata[8];
					res_q.good_frames     <= good_q;
					res_q.bad_frames      <= bad_q;
					res_q.dropped_frames  <= drop_q;
					res_q.queued_bytes    <= qcount_q - QCNT_W'(1);
					state_q               <= ST_IDLE;
				end
				ST_DONE: begin
					res_valid_q           <= 1'b1;
					res_q.out_valid       <= 1'b0;
					res_q.out_byte        <= 8'd0;
					res_q.out_last        <= 1'b0;
					res_q.good_frames     <= good_q;
					res_q.bad_frames      <= bad_q;
					res_q.dropped_frames  <= drop_q;
					res_q.queued_bytes    <= qcount_q;
					state_q               <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/sync_length_checksum_deframer_core.sv */
`timescale 1ns / 1ps
// Flow: a pop goes through ST_POP (ST_DONE if the queue is empty) to its registered result;
// a push runs the sync hunt, length check, checksum pass and copy of a good frame.
// Throughput: one transaction at a time in the back end; the window RAM read port
// (one byte per cycle) bounds the scan. A two-entry command queue takes input meanwhile.
// Reset (arst_n low): counters, window and queue pointers clear, sync word returns
// to 0xAA 0x55; RAM contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Byte stream deframer: sync hunt, length field, 8-bit additive checksum,
// output queue of good frames popped byte by byte.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core
	import sld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [7:0]        byte_in,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic [31:0]       good_frames,
	output logic [31:0]       bad_frames,
	output logic [31:0]       dropped_frames,
	output logic [QCNT_W-1:0] queued_bytes
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	res_t res;

	sld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.byte_in   (byte_in),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	sld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign out_valid      = res.out_valid;
	assign out_byte       = res.out_byte;
	assign out_last       = res.out_last;
	assign good_frames    = res.good_frames;
	assign bad_frames     = res.bad_frames;
	assign dropped_frames = res.dropped_frames;
	assign queued_bytes   = res.queued_bytes;

`ifndef NO_ASSERTIONS
	// back end is not ready again in the cycle after taking a command
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("back end took two commands in a row");

	// a full command queue always has a command on offer
	a_front_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> cmd_valid)
		else $error("front stalled with no pending command");

	// a result without data (push or empty pop) carries zero byte and no last mark
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0 && !out_last)
		else $error("result without data carries a byte");

	// queue occupancy never exceeds its depth
	a_qdepth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> queued_bytes <= QCNT_W'(QUE_DEPTH))
		else $error("output queue overfilled");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sync_length_checksum_deframer_core. Byte streams of framed
// data (good, corrupted and oversize frames, noise, broken sync) and pops are
// driven over valid/ready with random gaps and result stalls. A scoreboard
// class tracks the window, output queue and counters and compares every
// result transaction field by field. Sync word settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import sld_pkg::*;

	// scoreboard: holds the deframer state and the expected result transactions
	class frame_scoreboard;
		logic [7:0]        sync_a, sync_b;
		logic [7:0]        win_mem [WIN_DEPTH];
		int unsigned       win_start, win_fill;
		logic [8:0]        que_mem [QUE_DEPTH];
		int unsigned       que_head, que_cnt;
		logic [31:0]       good_cnt, bad_cnt, drop_cnt;
		res_t              expected_q[$];
		int                errors;

		function new();
			sync_a = 8'hAA;
			sync_b = 8'h55;
			win_start = 0;
			win_fill = 0;
			que_head = 0;
			que_cnt = 0;
			good_cnt = 0;
			bad_cnt = 0;
			drop_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == REG_SYNC_FIRST)
				sync_a = val;
			else
				sync_b = val;
		endfunction

		function logic [7:0] win_byte(int unsigned ofs);
			return win_mem[(win_start + ofs) % WIN_DEPTH];
		endfunction

		function void win_discard(int unsigned n);
			if (n > win_fill)
				n = win_fill;
			win_start = (win_start + n) % WIN_DEPTH;
			win_fill -= n;
		endfunction

		// hunt, length check, checksum, queue or drop
		function void scan_window();
			int unsigned i, flen, k;
			logic [7:0]  sum;
			while (win_fill > 0) begin
				i = 0;
				while (i < win_fill && win_byte(i) != sync_a)
					i++;
				if (i == win_fill) begin
					win_discard(win_fill);
					return;
				end
				win_discard(i);
				if (win_fill > 1 && win_byte(1) != sync_b) begin
					win_discard(1);
					continue;
				end
				if (win_fill < MIN_HEAD)
					return;
				flen = {win_byte(LEN_HI_OFS), win_byte(LEN_LO_OFS)} + FRAME_EXTRA;
				if (flen > WIN_DEPTH) begin
					bad_cnt++;
					win_discard(1);
					continue;
				end
				if (flen > win_fill)
					return;
				sum = 8'h00;
				for (k = LEN_LO_OFS; k + 1 < flen; k++)
					sum += win_byte(k);
				if (sum == win_byte(flen - 1)) begin
					good_cnt++;
					if (que_cnt + flen <= QUE_DEPTH) begin
						for (k = 0; k < flen; k++) begin
							que_mem[(que_head + que_cnt) % QUE_DEPTH] =
								{(k + 1 == flen), win_byte(k)};
							que_cnt++;
						end
					end else begin
						drop_cnt++;
					end
					win_discard(flen);
				end else begin
					bad_cnt++;
					win_discard(1);
				end
			end
		endfunction

		// accepted input transaction: update state, queue the expected result
		function void note_input(logic act, logic [7:0] data);
			res_t r;
			r = '0;
			if (act == ACT_PUSH) begin
				if (win_fill >= WIN_DEPTH)
					win_discard(1);
				win_mem[(win_start + win_fill) % WIN_DEPTH] = data;
				win_fill++;
				scan_window();
			end else if (que_cnt > 0) begin
				r.out_valid = 1'b1;
				r.out_byte  = que_mem[que_head][7:0];
				r.out_last  = que_mem[que_head][8];
				que_head = (que_head + 1) % QUE_DEPTH;
				que_cnt--;
			end
			r.good_frames    = good_cnt;
			r.bad_frames     = bad_cnt;
			r.dropped_frames = drop_cnt;
			r.queued_bytes   = QCNT_W'(que_cnt);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// accepted result transaction: compare with the oldest expectation
		function void check_result(res_t got);
			res_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transaction %p", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.out_valid !== exp_r.out_valid) begin
				$display("%0t: out_valid exp %0d got %0d", $time, exp_r.out_valid,
					got.out_valid);
				errors++;
			end
			if (got.out_byte !== exp_r.out_byte) begin
				$display("%0t: out_byte exp %h got %h", $time, exp_r.out_byte, got.out_byte);
				errors++;
			end
			if (got.out_last !== exp_r.out_last) begin
				$display("%0t: out_last exp %0d got %0d", $time, exp_r.out_last,
					got.out_last);
				errors++;
			end
			if (got.good_frames !== exp_r.good_frames) begin
				$display("%0t: good_frames exp %0d got %0d", $time, exp_r.good_frames,
					got.good_frames);
				errors++;
			end
			if (got.bad_frames !== exp_r.bad_frames) begin
				$display("%0t: bad_frames exp %0d got %0d", $time, exp_r.bad_frames,
					got.bad_frames);
				errors++;
			end
			if (got.dropped_frames !== exp_r.dropped_frames) begin
				$display("%0t: dropped_frames exp %0d got %0d", $time, exp_r.dropped_frames,
					got.dropped_frames);
				errors++;
			end
			if (got.queued_bytes !== exp_r.queued_bytes) begin
				$display("%0t: queued_bytes exp %0d got %0d", $time, exp_r.queued_bytes,
					got.queued_bytes);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_idx;
	logic [7:0]        cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              action;
	logic [7:0]        byte_in;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid;
	logic [7:0]        out_byte;
	logic              out_last;
	logic [31:0]       good_frames;
	logic [31:0]       bad_frames;
	logic [31:0]       dropped_frames;
	logic [QCNT_W-1:0] queued_bytes;

	frame_scoreboard sb = new();
	int              idle_pct;
	int              sent;
	logic [7:0]      cur_a, cur_b;

	sync_length_checksum_deframer_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .byte_in(byte_in),
		.res_valid(res_valid), .res_ready(res_ready),
		.out_valid(out_valid), .out_byte(out_byte), .out_last(out_last),
		.good_frames(good_frames), .bad_frames(bad_frames),
		.dropped_frames(dropped_frames), .queued_bytes(queued_bytes)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

	// monitors: accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(action, byte_in);
		if (arst_n && res_valid && res_ready)
			sb.check_result({out_valid, out_byte, out_last, good_frames, bad_frames,
				dropped_frames, queued_bytes});
	end

	// result side stalls
	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= idle_pct);

	task automatic send_item(logic act, logic [7:0] data);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		byte_in  <= data;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic push_byte(logic [7:0] data);
		send_item(ACT_PUSH, data);
	endtask

	task automatic pop_bytes(int n);
		repeat (n)
			send_item(ACT_POP, 8'($urandom));
	endtask

	// full frame; corrupt flips checksum bits, oversize sends only the header
	task automatic send_frame(int unsigned len, bit corrupt, bit oversize);
		logic [7:0] sum;
		logic [7:0] b;
		push_byte(cur_a);
		push_byte(cur_b);
		repeat (14)
			push_byte(8'($urandom));
		push_byte(len[7:0]);
		push_byte(len[15:8]);
		if (oversize)
			return;
		sum = len[7:0] + len[15:8];
		repeat (len) begin
			b = 8'($urandom);
			sum += b;
			push_byte(b);
		end
		if (corrupt)
			sum ^= 8'($urandom_range(255, 1));
		push_byte(sum);
	endtask

	// wait for all results, then let the back end settle before a register write
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (60)
			@(negedge clk);
	endtask

	task automatic write_sync(logic [7:0] a, logic [7:0] b);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SYNC_FIRST;
		cfg_data <= a;
		@(negedge clk);
		cfg_idx  <= REG_SYNC_SECOND;
		cfg_data <= b;
		@(negedge clk);
		cfg_we   <= 1'b0;
		sb.set_reg(REG_SYNC_FIRST, a);
		sb.set_reg(REG_SYNC_SECOND, b);
		cur_a = a;
		cur_b = b;
	endtask

	// random mix: frames (some corrupt), oversize headers, noise, broken sync and pops
	task automatic random_phase(int items);
		int start, pick;
		start = sent;
		while (sent - start < items) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_frame(($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12),
					$urandom_range(99) < 15, 1'b0);
			else if (pick < 52)
				send_frame($urandom_range(16'hFFFF, 4078), 1'b0, 1'b1);
			else if (pick < 62)
				repeat ($urandom_range(4, 1))
					push_byte(($urandom_range(3) == 0) ? cur_a : 8'($urandom));
			else if (pick < 66) begin
				push_byte(cur_a);
				push_byte(8'($urandom));
			end else
				pop_bytes($urandom_range(30, 1));
		end
		pop_bytes(sb.que_cnt + 2);
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_SYNC_FIRST;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		action   = ACT_PUSH;
		byte_in  = 8'h00;
		idle_pct = 10;
		sent     = 0;
		cur_a    = 8'hAA;
		cur_b    = 8'h55;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty pop, noise, broken sync, a good frame, pops
		pop_bytes(1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(cur_a);
		push_byte(8'h00);
		send_frame(0, 1'b0, 1'b0);
		pop_bytes(3);
		wait_drained();

		// extremes of the sync word, including a frame with maximal length bytes
		write_sync(8'h00, 8'hFF);
		send_frame(1, 1'b1, 1'b0);
		send_frame(16'hFFFF, 1'b0, 1'b1);
		send_frame(2, 1'b0, 1'b0);
		pop_bytes(25);
		wait_drained();

		// swapped extreme sync bytes, no idling on either side
		write_sync(8'hFF, 8'h00);
		idle_pct = 0;

		// random phases over several sync settings, the first with no idling
		random_phase(200);
		wait_drained();
		idle_pct = 10;
		write_sync(8'hAA, 8'h55);
		random_phase(220);
		wait_drained();
		write_sync(8'($urandom), 8'($urandom));
		random_phase(180);
		wait_drained();
		write_sync(8'h7E, 8'h7E);
		random_phase(120);
		wait_drained();

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
